[design/chi_square_array_distance_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the chi-square array distance block
// Short forms for clocked implication checks; reset masks every check.
// ----------------------------------------------------------------------------
`ifndef CHI_SQUARE_ARRAY_DISTANCE_TOP_MACROS_SVH
`define CHI_SQUARE_ARRAY_DISTANCE_TOP_MACROS_SVH

// Same-cycle implication.
`define CHISQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CHISQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/chisq_pkg.sv]
// ----------------------------------------------------------------------------
// chisq_pkg
// Shared types, widths and helpers for the chi-square array distance block.
// ----------------------------------------------------------------------------
package chisq_pkg;

  localparam int DEFAULT_ELEMENT_WIDTH = 16;
  localparam int FIELD_W               = 16;
  localparam int SUM_W                 = 32;

  // Elements wider than the field are the field zero-extended, so one extra
  // bit covers them.
  function automatic int val_width(input int ew);
    return (ew > FIELD_W) ? FIELD_W + 1 : ew;
  endfunction

  // Magnitude of a difference or a sum of two elements.
  function automatic int mag_width(input int ew);
    return val_width(ew) + 1;
  endfunction

  // Dividend width: square of a magnitude; also the number of divide steps.
  function automatic int num_width(input int ew);
    return 2 * mag_width(ew);
  endfunction

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_DIVIDE,
    ST_ACCUM
  } ctrl_state_t;

  typedef struct packed {
    logic load_in;
    logic div_init;
    logic div_step;
    logic acc_en;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_div;
    logic last;
    logic slot_free;
  } dp_stat_t;

endpackage

[design/chisq_ctrl.sv]
// ----------------------------------------------------------------------------
// chisq_ctrl
// Sequencer: takes one request, squares, runs the divide steps if needed, accumulates.
// ----------------------------------------------------------------------------
`include "chi_square_array_distance_top_macros.svh"

module chisq_ctrl
  import chisq_pkg::*;
#(
  parameter int ELEMENT_WIDTH = DEFAULT_ELEMENT_WIDTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  localparam int NUM_W = num_width(ELEMENT_WIDTH);
  localparam int CNT_W = $clog2(NUM_W);

  ctrl_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        if (stat.need_div) begin
          cmd.div_init = 1'b1;
          cnt_nxt      = CNT_W'(NUM_W - 1);
          state_nxt    = ST_DIVIDE;
        end else begin
          state_nxt = ST_ACCUM;
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_ACCUM;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_ACCUM: begin
        // hold a final request while the result register is still full and stalled
        if (!stat.last || stat.slot_free) begin
          cmd.acc_en = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `CHISQ_ASSERT_NEXT(a_accept_starts, state_r == ST_IDLE && in_valid, state_r == ST_SQUARE, "accepted request did not start")
  `CHISQ_ASSERT_NEXT(a_div_ends, state_r == ST_DIVIDE && cnt_r == '0, state_r == ST_ACCUM, "divide did not end on count")
  `CHISQ_ASSERT_NEXT(a_skip_div, state_r == ST_SQUARE && !stat.need_div, state_r == ST_ACCUM, "divide not skipped")

endmodule

[design/chisq_dp.sv]
// ----------------------------------------------------------------------------
// chisq_dp
// Datapath: operand capture, square, restoring divider, accumulator, result.
// ----------------------------------------------------------------------------
`include "chi_square_array_distance_top_macros.svh"

module chisq_dp
  import chisq_pkg::*;
#(
  parameter int ELEMENT_WIDTH = DEFAULT_ELEMENT_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic signed [FIELD_W-1:0] in_first_value,
  input  logic signed [FIELD_W-1:0] in_second_value,
  input  logic                      in_first_present,
  input  logic                      in_second_present,
  input  logic                      in_final_index,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [SUM_W-1:0]   out_distance,
  output logic                      out_zero_divisor_seen,
  input  ctrl_cmd_t                 cmd,
  output dp_stat_t                  stat
);

  localparam int VAL_W = val_width(ELEMENT_WIDTH);
  localparam int MAG_W = mag_width(ELEMENT_WIDTH);
  localparam int NUM_W = num_width(ELEMENT_WIDTH);
  localparam int QX_W  = (NUM_W + 1 > SUM_W) ? NUM_W + 1 : SUM_W;

  // operand capture
  logic signed [VAL_W-1:0] a_r, b_r;
  logic signed [MAG_W-1:0] s_r;
  logic        [MAG_W-1:0] d_mag_r;
  logic                    pa_r, pb_r, last_r;

  // divider
  logic [NUM_W-1:0] quo_r;
  logic [MAG_W-1:0] rem_r, den_r;
  logic             neg_r;

  // accumulator and result
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic             fault_r, fault_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [SUM_W-1:0] out_dist_r;
  logic             out_zds_r;

  logic [FIELD_W:0]         a_ext, b_ext;
  logic signed [VAL_W-1:0]  a_in, b_in;
  logic signed [MAG_W-1:0]  d_in, s_in;
  logic [MAG_W:0]           trial;
  logic                     ge;
  logic signed [QX_W-1:0]   qx;
  logic [SUM_W-1:0]         term;
  logic                     fault_hit;

  // an element wider than the field comes out zero-extended
  always_comb begin
    a_ext = {1'b0, in_first_value};
    b_ext = {1'b0, in_second_value};
    a_in  = signed'(a_ext[VAL_W-1:0]);
    b_in  = signed'(b_ext[VAL_W-1:0]);
    d_in  = MAG_W'(a_in) - MAG_W'(b_in);
    s_in  = MAG_W'(a_in) + MAG_W'(b_in);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      a_r     <= a_in;
      b_r     <= b_in;
      s_r     <= s_in;
      d_mag_r <= d_in[MAG_W-1] ? MAG_W'(-d_in) : MAG_W'(d_in);
      pa_r    <= in_first_present;
      pb_r    <= in_second_present;
      last_r  <= in_final_index;
    end
  end

  // one quotient bit per step
  always_comb begin
    trial = {rem_r, quo_r[NUM_W-1]};
    ge    = trial >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      quo_r <= NUM_W'(d_mag_r) * NUM_W'(d_mag_r);
      rem_r <= '0;
      den_r <= s_r[MAG_W-1] ? MAG_W'(-s_r) : MAG_W'(s_r);
      neg_r <= s_r[MAG_W-1];
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[NUM_W-2:0], ge};
      rem_r <= ge ? MAG_W'(trial - {1'b0, den_r}) : trial[MAG_W-1:0];
    end
  end

  always_comb begin
    stat.need_div  = pa_r && pb_r && (s_r != '0);
    stat.last      = last_r;
    stat.slot_free = !out_valid_r || !out_stall;
    fault_hit      = pa_r && pb_r && (s_r == '0) && (a_r != '0);

    qx = QX_W'(signed'({1'b0, quo_r}));
    if (neg_r) begin
      qx = -qx;
    end

    if (pa_r && pb_r) begin
      term = stat.need_div ? qx[SUM_W-1:0] : '0;
    end else if (pa_r) begin
      term = SUM_W'(a_r);
    end else if (pb_r) begin
      term = SUM_W'(b_r);
    end else begin
      term = '0;
    end

    sum_nxt       = sum_r;
    fault_nxt     = fault_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.acc_en) begin
      if (last_r) begin
        sum_nxt       = '0;
        fault_nxt     = 1'b0;
        out_valid_nxt = 1'b1;
      end else begin
        sum_nxt   = sum_r + term;
        fault_nxt = fault_r || fault_hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      fault_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sum_r       <= sum_nxt;
      fault_r     <= fault_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_en && last_r) begin
      out_dist_r <= sum_r + term;
      out_zds_r  <= fault_r || fault_hit;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_distance          = signed'(out_dist_r);
  assign out_zero_divisor_seen = out_zds_r;

  `CHISQ_ASSERT_IMP(a_no_overwrite, cmd.acc_en && last_r,
                    !(out_valid_r && out_stall), "result overwritten while stalled")
  `CHISQ_ASSERT_NEXT(a_sum_cleared, cmd.acc_en && last_r,
                     sum_r == '0 && !fault_r, "sum not cleared after final")
  `CHISQ_ASSERT_NEXT(a_rem_bound, cmd.div_step,
                     rem_r < den_r, "remainder not below divisor")

endmodule

[design/chi_square_array_distance_top.sv]
// ----------------------------------------------------------------------------
// chi_square_array_distance_top
// Chi-square distance between two streamed arrays, one index per request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one request per array index carries both elements,
//   their present bits and the final marker. in_stall is low only while the
//   block is free for a new request.
//   Result channel (out_*): one result per request marked final, holding the
//   wrapped 32-bit sum and the zero-divisor flag; running sum and flag clear.
// Timing:
//   A request with both elements present and a nonzero sum runs the square
//   step, the divide steps and the accumulate step; the bit-serial divider
//   gives one quotient bit per cycle. Any other request skips the divide
//   steps. A result appears the cycle after the accumulate step.
// Stall:
//   The result register holds while out_stall is high; the next request is
//   still taken and worked on, and a following final request waits in the
//   accumulate step until the register is free.
// Reset:
//   rst_n low clears the sum, the fault flag and the result valid.
// ----------------------------------------------------------------------------
module chi_square_array_distance_top
  import chisq_pkg::*;
#(
  parameter int ELEMENT_WIDTH = DEFAULT_ELEMENT_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [FIELD_W-1:0] in_first_value,
  input  logic signed [FIELD_W-1:0] in_second_value,
  input  logic                      in_first_present,
  input  logic                      in_second_present,
  input  logic                      in_final_index,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [SUM_W-1:0]   out_distance,
  output logic                      out_zero_divisor_seen
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  chisq_ctrl #(
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  chisq_dp #(
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_first_value        (in_first_value),
    .in_second_value       (in_second_value),
    .in_first_present      (in_first_present),
    .in_second_present     (in_second_present),
    .in_final_index        (in_final_index),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_distance          (out_distance),
    .out_zero_divisor_seen (out_zero_divisor_seen),
    .cmd                   (cmd),
    .stat                  (stat)
  );

endmodule
